// File: sv/tcd_pkg.sv
// Shared types, constants and opcodes for the toy CPU decode and execute block.
`timescale 1ns / 1ps
`default_nettype none

package tcd_pkg;

    // Data word width and storage sizes.
    localparam int XLEN       = 16;
    localparam int REG_COUNT  = 16;
    localparam int REG_AW     = 4;
    localparam int DATA_WORDS = 32768;
    localparam int DATA_AW    = $clog2(DATA_WORDS);

    // Opcodes.
    localparam logic [7:0] OP_HALT = 8'd0;
    localparam logic [7:0] OP_LOAD = 8'd1;
    localparam logic [7:0] OP_ADD  = 8'd2;
    localparam logic [7:0] OP_SUB  = 8'd3;
    localparam logic [7:0] OP_MUL  = 8'd4;
    localparam logic [7:0] OP_DIV  = 8'd5;
    localparam logic [7:0] OP_AND  = 8'd6;
    localparam logic [7:0] OP_OR   = 8'd7;
    localparam logic [7:0] OP_NOT  = 8'd8;
    localparam logic [7:0] OP_CMP  = 8'd9;
    localparam logic [7:0] OP_JMP  = 8'd10;
    localparam logic [7:0] OP_IN   = 8'd11;
    localparam logic [7:0] OP_OUT  = 8'd12;

    // Jump conditions, carried in the rb field.
    localparam logic [3:0] JC_ALWAYS = 4'd0;
    localparam logic [3:0] JC_EQ     = 4'd1;
    localparam logic [3:0] JC_GT     = 4'd2;
    localparam logic [3:0] JC_LT     = 4'd3;

    // Load with a register address: ra below this loads, otherwise it stores.
    localparam logic [3:0] LOAD_SPLIT = 4'd5;

    // Bias that makes the arithmetic shift by two round toward zero.
    localparam logic [XLEN:0] JMP_BIAS = 17'd3;

    typedef enum logic [1:0] {
        FLAG_EQ = 2'd0,
        FLAG_GT = 2'd1,
        FLAG_LT = 2'd3
    } flag_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_CMP
    } alu_op_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_SIMPLE,
        A_ABSA,
        A_ABSB,
        A_ITER,
        A_FIX,
        A_DONE
    } alu_st_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDB,
        S_RDA,
        S_MEM,
        S_EXEC,
        S_WAIT,
        S_FINISH
    } st_t;

    typedef struct packed {
        logic [31:0]        instr_word;
        logic signed [15:0] in_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic               out_valid;
        logic signed [15:0] out_value;
        logic               halted;
        logic               div_error;
    } out_item_t;

    typedef struct packed {
        logic            start;
        alu_op_t         op;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic            done;
        logic [XLEN-1:0] result;
        flag_t           flag;
        logic            div_zero;
    } alu_rsp_t;

    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } rf_wr_t;

    typedef struct packed {
        logic               we;
        logic [DATA_AW-1:0] addr;
        logic [XLEN-1:0]    data;
    } mem_wr_t;

endpackage

`default_nettype wire

// File: sv/tcd_regfile.sv
// Register file with one registered read port and one write port.
`timescale 1ns / 1ps
`default_nettype none

module tcd_regfile (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tcd_pkg::REG_AW-1:0]  raddr,
    output logic [tcd_pkg::XLEN-1:0]    rdata,
    input  tcd_pkg::rf_wr_t             wr
);
    import tcd_pkg::*;

    localparam logic [REG_AW:0] REG_LIMIT = (REG_AW + 1)'(REG_COUNT);

    logic [XLEN-1:0] regs_reg [REG_COUNT];
    logic [XLEN-1:0] rdata_reg;
    logic            rd_ok;
    logic            wr_ok;

    // Indices at or above the register count read as zero and drop writes.
    assign rd_ok = {1'b0, raddr} < REG_LIMIT;
    assign wr_ok = wr.we && ({1'b0, wr.addr} < REG_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (wr_ok)
        begin
            regs_reg[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= rd_ok ? regs_reg[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/tcd_dmem.sv
// Data memory with a registered read port, one write port and a clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module tcd_dmem (
    input  logic                        clk,
    input  logic                        rst_n,
    output logic                        busy,
    input  logic [tcd_pkg::DATA_AW-1:0] raddr,
    output logic [tcd_pkg::XLEN-1:0]    rdata,
    input  tcd_pkg::mem_wr_t            wr
);
    import tcd_pkg::*;

    localparam logic [DATA_AW-1:0] LAST_ADDR = DATA_AW'(DATA_WORDS - 1);

    logic [XLEN-1:0]    mem [DATA_WORDS];
    logic [XLEN-1:0]    rdata_reg;
    logic [DATA_AW-1:0] clr_cnt_reg;
    logic               busy_reg;

    // After reset every entry is zeroed, one per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign busy  = busy_reg;
    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/tcd_alu.sv
// Shared iterative arithmetic unit: add, subtract, compare, multiply and divide on one adder.
`timescale 1ns / 1ps
`default_nettype none

module tcd_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  tcd_pkg::alu_req_t req,
    output tcd_pkg::alu_rsp_t rsp
);
    import tcd_pkg::*;

    localparam logic [3:0] LAST_STEP = 4'(XLEN - 1);

    alu_st_t         st_reg, st_next;
    alu_op_t         op_reg, op_next;
    logic [XLEN-1:0] x_reg, x_next;
    logic [XLEN-1:0] y_reg, y_next;
    logic [XLEN-1:0] z_reg, z_next;
    logic [XLEN-1:0] res_reg, res_next;
    logic            neg_reg, neg_next;
    logic            dz_reg, dz_next;
    flag_t           flag_reg, flag_next;
    logic [3:0]      cnt_reg, cnt_next;

    logic [XLEN:0]   add_x;
    logic [XLEN:0]   add_y;
    logic            add_sub;
    logic [XLEN:0]   add_sum;

    // The single adder that every operation goes through.
    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + (XLEN + 1)'(add_sub);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        ALU_MUL: st_next = A_ITER;
                        ALU_DIV: st_next = (req.b == '0) ? A_DONE : A_ABSA;
                        default: st_next = A_SIMPLE;
                    endcase
                end
            end
            A_SIMPLE: st_next = A_DONE;
            A_ABSA:   st_next = A_ABSB;
            A_ABSB:   st_next = A_ITER;
            A_ITER:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    st_next = (op_reg == ALU_DIV) ? A_FIX : A_DONE;
                end
            end
            A_FIX:    st_next = A_DONE;
            A_DONE:   st_next = A_IDLE;
            default:  st_next = A_IDLE;
        endcase
    end

    always_comb
    begin
        op_next   = op_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        res_next  = res_reg;
        neg_next  = neg_reg;
        dz_next   = dz_reg;
        flag_next = flag_reg;
        cnt_next  = cnt_reg;
        add_x     = '0;
        add_y     = '0;
        add_sub   = 1'b0;
        case (st_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    cnt_next = '0;
                    neg_next = req.a[XLEN-1] ^ req.b[XLEN-1];
                    dz_next  = 1'b0;
                    case (req.op)
                        ALU_MUL:
                        begin
                            x_next = '0;
                            y_next = req.a;
                            z_next = req.b;
                        end
                        ALU_DIV:
                        begin
                            x_next  = '0;
                            y_next  = req.b;
                            z_next  = req.a;
                            dz_next = (req.b == '0);
                        end
                        default:
                        begin
                            x_next = req.a;
                            y_next = req.b;
                        end
                    endcase
                end
            end
            A_SIMPLE:
            begin
                add_x    = {x_reg[XLEN-1], x_reg};
                add_y    = {y_reg[XLEN-1], y_reg};
                add_sub  = (op_reg != ALU_ADD);
                res_next = add_sum[XLEN-1:0];
                if (add_sum == '0)
                begin
                    flag_next = FLAG_EQ;
                end
                else if (add_sum[XLEN])
                begin
                    flag_next = FLAG_LT;
                end
                else
                begin
                    flag_next = FLAG_GT;
                end
            end
            A_ABSA:
            begin
                add_y   = {z_reg[XLEN-1], z_reg};
                add_sub = z_reg[XLEN-1];
                z_next  = add_sum[XLEN-1:0];
            end
            A_ABSB:
            begin
                add_y   = {y_reg[XLEN-1], y_reg};
                add_sub = y_reg[XLEN-1];
                y_next  = add_sum[XLEN-1:0];
            end
            A_ITER:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (op_reg == ALU_MUL)
                begin
                    // Shift and add, keeping the low half of the product.
                    add_x  = {1'b0, x_reg};
                    add_y  = {1'b0, y_reg};
                    y_next = {y_reg[XLEN-2:0], 1'b0};
                    z_next = {1'b0, z_reg[XLEN-1:1]};
                    if (z_reg[0])
                    begin
                        x_next   = add_sum[XLEN-1:0];
                        res_next = add_sum[XLEN-1:0];
                    end
                    else
                    begin
                        res_next = x_reg;
                    end
                end
                else
                begin
                    // Restoring division on the magnitudes, one quotient bit a step.
                    add_x   = {x_reg, z_reg[XLEN-1]};
                    add_y   = {1'b0, y_reg};
                    add_sub = 1'b1;
                    if (!add_sum[XLEN])
                    begin
                        x_next = add_sum[XLEN-1:0];
                        z_next = {z_reg[XLEN-2:0], 1'b1};
                    end
                    else
                    begin
                        x_next = {x_reg[XLEN-2:0], z_reg[XLEN-1]};
                        z_next = {z_reg[XLEN-2:0], 1'b0};
                    end
                end
            end
            A_FIX:
            begin
                add_y    = {1'b0, z_reg};
                add_sub  = neg_reg;
                res_next = add_sum[XLEN-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp.done     = (st_reg == A_DONE);
        rsp.result   = res_reg;
        rsp.flag     = flag_reg;
        rsp.div_zero = dz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= A_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        res_reg  <= res_next;
        neg_reg  <= neg_next;
        dz_reg   <= dz_next;
        flag_reg <= flag_next;
        cnt_reg  <= cnt_next;
    end

endmodule

`default_nettype wire

// File: sv/toy_cpu_decode_execute.sv
// Top level of the toy CPU decode and execute block: sequencer, result register and units.
// An accepted beat steps through S_RDB, S_RDA and S_MEM, then S_EXEC (a store skips it),
// S_WAIT on the arithmetic unit for add, subtract, compare, multiply and divide, and S_FINISH;
// once halted it goes straight to S_FINISH. The next beat is taken the cycle after the result
// is loaded; the shared iterative arithmetic unit and the single read ports shape these steps.
// Reset is asynchronous and active low; afterwards all 32768 data memory words are zeroed in a
// clearing pass, during which no instruction beat is accepted.
`timescale 1ns / 1ps
`default_nettype none

module toy_cpu_decode_execute (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  tcd_pkg::in_item_t  cmd,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output tcd_pkg::out_item_t rsp
);
    import tcd_pkg::*;

    // Sequencer and architectural state.
    st_t             st_reg, st_next;
    logic [15:0]     pc_reg, pc_next;
    logic            halt_reg, halt_next;
    flag_t           flag_reg, flag_next;

    // The instruction being worked on and its operands.
    logic [7:0]        op_reg, op_next;
    logic [REG_AW-1:0] ra_reg, ra_next;
    logic [REG_AW-1:0] rb_reg, rb_next;
    logic [XLEN-1:0]   imm_reg, imm_next;
    logic [XLEN-1:0]   inv_reg, inv_next;
    logic [XLEN-1:0]   rav_reg, rav_next;
    logic [XLEN-1:0]   rbv_reg, rbv_next;
    logic [15:0]       step_reg, step_next;
    logic              ovalid_reg, ovalid_next;
    logic [XLEN-1:0]   oval_reg, oval_next;
    logic              derr_reg, derr_next;

    // Result register.
    logic              rsp_valid_reg, rsp_valid_next;
    out_item_t         rsp_reg, rsp_next;

    // Unit connections.
    logic              accept;
    logic              rsp_free;
    logic              mem_busy;
    logic [REG_AW-1:0] rf_raddr;
    logic [XLEN-1:0]   rf_rdata;
    rf_wr_t            rf_wr;
    logic [DATA_AW-1:0] mem_raddr;
    logic [XLEN-1:0]   mem_rdata;
    mem_wr_t           mem_wr;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    // Decode of the held instruction.
    logic              is_store;
    logic              is_alu_op;
    logic [XLEN-1:0]   bval;
    logic              jmp_take;
    logic [XLEN:0]     jmp_sum;
    logic [15:0]       jmp_off;
    alu_op_t           alu_op;

    // A beat is taken only between instructions and never while memory is being cleared.
    assign cmd_stall = (st_reg != S_IDLE) || mem_busy;
    assign accept    = cmd_valid && !cmd_stall;

    // The result register frees up in the same cycle that its beat leaves.
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A load with a nonzero rb and ra at or above the split point is a store.
    assign is_store  = (op_reg == OP_LOAD) && (rb_reg != '0) && (ra_reg >= LOAD_SPLIT);
    assign is_alu_op = op_reg inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP};

    // The second operand is the immediate when rb is zero, else the memory word at reg[rb].
    assign bval = (rb_reg == '0) ? imm_reg : mem_rdata;

    // imm / 4 rounded toward zero: bias negative values by three, then shift.
    assign jmp_sum = {imm_reg[XLEN-1], imm_reg} + (imm_reg[XLEN-1] ? JMP_BIAS : '0);
    assign jmp_off = {jmp_sum[XLEN], jmp_sum[XLEN:2]};

    always_comb
    begin
        case (rb_reg)
            JC_ALWAYS: jmp_take = 1'b1;
            JC_EQ:     jmp_take = (flag_reg == FLAG_EQ);
            JC_GT:     jmp_take = (flag_reg == FLAG_GT);
            JC_LT:     jmp_take = (flag_reg == FLAG_LT);
            default:   jmp_take = 1'b0;
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_SUB:  alu_op = ALU_SUB;
            OP_MUL:  alu_op = ALU_MUL;
            OP_DIV:  alu_op = ALU_DIV;
            OP_CMP:  alu_op = ALU_CMP;
            default: alu_op = ALU_ADD;
        endcase
    end

    // The register file is read at rb first and at ra in the following cycle.
    assign rf_raddr  = (st_reg == S_RDB) ? rb_reg : ra_reg;
    // Every memory read is addressed by reg[rb] (a store writes at reg[ra]); the read is issued each cycle.
    assign mem_raddr = rbv_reg[DATA_AW-1:0];

    // Next state of the sequencer.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    st_next = halt_reg ? S_FINISH : S_RDB;
                end
            end
            S_RDB:  st_next = S_RDA;
            S_RDA:  st_next = S_MEM;
            S_MEM:  st_next = is_store ? S_FINISH : S_EXEC;
            S_EXEC: st_next = is_alu_op ? S_WAIT : S_FINISH;
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    st_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (rsp_free)
                begin
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    // Datapath and unit controls for each step.
    always_comb
    begin
        pc_next        = pc_reg;
        halt_next      = halt_reg;
        flag_next      = flag_reg;
        op_next        = op_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        imm_next       = imm_reg;
        inv_next       = inv_reg;
        rav_next       = rav_reg;
        rbv_next       = rbv_reg;
        step_next      = step_reg;
        ovalid_next    = ovalid_reg;
        oval_next      = oval_reg;
        derr_next      = derr_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        rf_wr          = '0;
        mem_wr         = '0;
        alu_req.start  = 1'b0;
        alu_req.op     = alu_op;
        alu_req.a      = rav_reg;
        alu_req.b      = bval;

        case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = cmd.instr_word[31:24];
                    ra_next     = cmd.instr_word[23:20];
                    rb_next     = cmd.instr_word[19:16];
                    imm_next    = cmd.instr_word[15:0];
                    inv_next    = cmd.in_value;
                    // Once halted the word is ignored and the program counter holds.
                    step_next   = halt_reg ? 16'd0 : 16'd1;
                    ovalid_next = 1'b0;
                    oval_next   = '0;
                    derr_next   = 1'b0;
                end
            end
            S_RDA:
            begin
                rbv_next = rf_rdata;
            end
            S_MEM:
            begin
                rav_next = rf_rdata;
                if (is_store)
                begin
                    mem_wr.we   = 1'b1;
                    mem_wr.addr = rf_rdata[DATA_AW-1:0];
                    mem_wr.data = rbv_reg;
                end
            end
            S_EXEC:
            begin
                rf_wr.addr = ra_reg;
                case (op_reg)
                    OP_HALT:
                    begin
                        halt_next = 1'b1;
                    end
                    OP_LOAD:
                    begin
                        // Stores finished earlier, so only loads reach this step.
                        rf_wr.we   = 1'b1;
                        rf_wr.data = bval;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP:
                    begin
                        alu_req.start = 1'b1;
                    end
                    OP_AND:
                    begin
                        rf_wr.we   = 1'b1;
                        rf_wr.data = XLEN'((rav_reg != '0) && (bval != '0));
                    end
                    OP_OR:
                    begin
                        rf_wr.we   = 1'b1;
                        rf_wr.data = XLEN'((rav_reg != '0) || (bval != '0));
                    end
                    OP_NOT:
                    begin
                        if (rb_reg == '0)
                        begin
                            rf_wr.we   = 1'b1;
                            rf_wr.data = XLEN'(rav_reg == '0);
                        end
                        else
                        begin
                            mem_wr.we   = 1'b1;
                            mem_wr.addr = rbv_reg[DATA_AW-1:0];
                            mem_wr.data = XLEN'(mem_rdata == '0);
                        end
                    end
                    OP_JMP:
                    begin
                        if (jmp_take)
                        begin
                            step_next = jmp_off;
                        end
                    end
                    OP_IN:
                    begin
                        rf_wr.we   = 1'b1;
                        rf_wr.data = inv_reg;
                    end
                    OP_OUT:
                    begin
                        ovalid_next = 1'b1;
                        oval_next   = rav_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WAIT:
            begin
                rf_wr.addr = ra_reg;
                rf_wr.data = alu_rsp.result;
                if (alu_rsp.done)
                begin
                    if (op_reg == OP_CMP)
                    begin
                        flag_next = alu_rsp.flag;
                    end
                    else if ((op_reg == OP_DIV) && alu_rsp.div_zero)
                    begin
                        // A zero divisor leaves the destination as it was.
                        derr_next = 1'b1;
                    end
                    else
                    begin
                        rf_wr.we = 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (rsp_free)
                begin
                    pc_next            = pc_reg + step_reg;
                    rsp_valid_next     = 1'b1;
                    rsp_next.next_pc   = pc_reg + step_reg;
                    rsp_next.out_valid = ovalid_reg;
                    rsp_next.out_value = oval_reg;
                    rsp_next.halted    = halt_reg;
                    rsp_next.div_error = derr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            flag_reg      <= FLAG_EQ;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            flag_reg      <= flag_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        imm_reg    <= imm_next;
        inv_reg    <= inv_next;
        rav_reg    <= rav_next;
        rbv_reg    <= rbv_next;
        step_reg   <= step_next;
        ovalid_reg <= ovalid_next;
        oval_reg   <= oval_next;
        derr_reg   <= derr_next;
        rsp_reg    <= rsp_next;
    end

    tcd_regfile u_regfile (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (rf_raddr),
        .rdata (rf_rdata),
        .wr    (rf_wr)
    );

    tcd_dmem u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (mem_busy),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .wr    (mem_wr)
    );

    tcd_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

endmodule

`default_nettype wire

// File: sv/tcd_check.sv
// Port-level checker for the toy CPU decode and execute block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tcd_check (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input tcd_pkg::in_item_t  cmd,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input tcd_pkg::out_item_t rsp
);
    import tcd_pkg::*;

    // A held result beat keeps its payload until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("result beat changed while stalled");

    // One instruction at a time: right after a beat is taken the block stalls.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("instruction beat taken while another is in flight");

    // An output instruction never reports a divide error.
    a_out_no_derr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.out_valid && rsp.div_error))
        else $error("output and divide error in the same result");

    // A halted result carries no output and no divide error.
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.halted) |-> (!rsp.out_valid && !rsp.div_error && rsp.out_value == '0))
        else $error("halted result with side fields set");

endmodule

bind toy_cpu_decode_execute tcd_check u_tcd_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the toy CPU decode and execute block.
`timescale 1ns / 1ps

module tb;
    import tcd_pkg::*;

    // The block clears its 32768-word data memory after reset, so the watchdog must
    // outlast that pass. It also has to outlast the long receiver hold-off.
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES    = 400;
    // The slowest instruction is divide; this margin covers any straggler.
    localparam int DRAIN_CYCLES   = 40;
    // An rb field of zero selects the immediate instead of a memory operand.
    localparam logic [3:0] NO_REG = 4'd0;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_stall;
    in_item_t   cmd;
    logic       rsp_valid;
    logic       rsp_stall;
    out_item_t  rsp;

    // Shared control between the sender, the receiver and the test tasks.
    bit         idle_on;
    bit         hold_req;
    int         fail_count;
    int         quiet_cycles;

    // Architectural state mirrored by the testbench, updated once per accepted beat.
    logic [15:0] arch_regs [0:REG_COUNT-1];
    logic [15:0] arch_mem [0:DATA_WORDS-1];
    flag_t       arch_flag;
    logic [15:0] arch_pc;
    bit          arch_halted;

    // Results of retired instructions, oldest first, waiting for the block to report them.
    out_item_t   retire_q[$];

    toy_cpu_decode_execute dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Executes one instruction word against the mirrored state and returns what the
    // block should report for it.
    function automatic out_item_t execute_instr(input in_item_t item);
        out_item_t   res;
        logic [7:0]  op;
        logic [3:0]  ra;
        logic [3:0]  rb;
        logic [15:0] imm;
        logic [15:0] av;
        logic [15:0] bv;
        logic [15:0] npc;
        logic [DATA_AW-1:0] ad;
        int          a;
        int          b;
        int          q;
        bit          take;

        res = '0;
        if (arch_halted)
        begin
            // Once halted, every word is dropped and the program counter stays put.
            res.next_pc = arch_pc;
            res.halted  = 1'b1;
            return res;
        end

        op  = item.instr_word[31:24];
        ra  = item.instr_word[23:20];
        rb  = item.instr_word[19:16];
        imm = item.instr_word[15:0];
        npc = arch_pc + 16'd1;
        ad  = arch_regs[rb][DATA_AW-1:0];
        av  = arch_regs[ra];
        bv  = (rb == NO_REG) ? imm : arch_mem[ad];
        a   = $signed(av);
        b   = $signed(bv);

        case (op)
            OP_HALT:
                arch_halted = 1'b1;
            OP_LOAD:
                if (rb == NO_REG)
                    arch_regs[ra] = imm;
                else if (ra < LOAD_SPLIT)
                    arch_regs[ra] = arch_mem[ad];
                else
                    arch_mem[arch_regs[ra][DATA_AW-1:0]] = arch_regs[rb];
            OP_ADD:
                arch_regs[ra] = av + bv;
            OP_SUB:
                arch_regs[ra] = av - bv;
            OP_MUL:
                arch_regs[ra] = av * bv;
            OP_DIV:
                if (b == 0)
                    res.div_error = 1'b1;
                else
                begin
                    // Signed division truncates toward zero; -32768 / -1 wraps.
                    q = a / b;
                    arch_regs[ra] = q[15:0];
                end
            OP_AND:
                arch_regs[ra] = {15'd0, (av != 0) && (bv != 0)};
            OP_OR:
                arch_regs[ra] = {15'd0, (av != 0) || (bv != 0)};
            OP_NOT:
                if (rb == NO_REG)
                    arch_regs[ra] = {15'd0, av == 0};
                else
                    arch_mem[ad] = {15'd0, arch_mem[ad] == 0};
            OP_CMP:
                arch_flag = (a == b) ? FLAG_EQ : ((a > b) ? FLAG_GT : FLAG_LT);
            OP_JMP:
            begin
                take = (rb == JC_ALWAYS) ||
                       (rb == JC_EQ && arch_flag == FLAG_EQ) ||
                       (rb == JC_GT && arch_flag == FLAG_GT) ||
                       (rb == JC_LT && arch_flag == FLAG_LT);
                if (take)
                begin
                    q   = $signed(imm) / 4;
                    npc = arch_pc + q[15:0];
                end
            end
            OP_IN:
                arch_regs[ra] = item.in_value;
            OP_OUT:
            begin
                res.out_valid = 1'b1;
                res.out_value = av;
            end
            default:
                ;
        endcase

        arch_pc     = npc;
        res.next_pc = npc;
        res.halted  = arch_halted;
        return res;
    endfunction

    function automatic in_item_t mk(input logic [7:0] op, input logic [3:0] ra,
                                    input logic [3:0] rb, input logic [15:0] imm,
                                    input logic [15:0] inv = 16'd0);
        in_item_t item;

        item.instr_word = {op, ra, rb, imm};
        item.in_value   = inv;
        return item;
    endfunction

    // Data values lean toward small numbers, so that registers used as addresses keep
    // landing on the same memory words, and toward the extremes of the 16-bit range.
    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        int          sel;

        sel = $urandom_range(99);
        if (sel < 40)
            v = 16'($urandom_range(15));
        else if (sel < 55)
            case ($urandom_range(3))
                0:       v = 16'h7FFF;
                1:       v = 16'h8000;
                2:       v = 16'hFFFF;
                default: v = 16'h0000;
            endcase
        else
            v = 16'($urandom);
        return v;
    endfunction

    // Most words are decodable instructions with random operands; one in ten is raw
    // noise. Halt is kept out, since it would freeze the block for the rest of the run.
    function automatic in_item_t random_word();
        in_item_t    item;
        logic [7:0]  op;
        logic [3:0]  ra;
        logic [3:0]  rb;
        logic [15:0] imm;

        item.in_value = pick_value();
        if ($urandom_range(99) < 10)
        begin
            item.instr_word = $urandom;
            if (item.instr_word[31:24] == OP_HALT)
                item.instr_word[31:24] = OP_OUT;
            return item;
        end
        op  = 8'($urandom_range(OP_LOAD, OP_OUT + 8'd3));
        ra  = 4'($urandom);
        rb  = $urandom_range(1) ? NO_REG : 4'($urandom);
        imm = pick_value();
        if (op == OP_JMP)
        begin
            rb  = 4'($urandom_range(JC_LT + 4'd2));
            imm = 16'($urandom);
        end
        item.instr_word = {op, ra, rb, imm};
        return item;
    endfunction

    // Sends one instruction beat. The payload changes at the falling edge and the beat
    // counts as taken at the rising edge where stall is low. Valid is left high after
    // acceptance so that back-to-back beats need no extra cycle; the next call either
    // replaces the payload or drops valid at the very next falling edge.
    task automatic send_word(input in_item_t item);
        @(negedge clk);
        if (idle_on && $urandom_range(99) < 14)
        begin
            cmd_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < 14);
        end
        cmd       <= item;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        retire_q.push_back(execute_instr(item));
    endtask

    // Drops valid and waits until every retired instruction has been reported.
    task automatic wait_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (retire_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // Loads, stores with an address that wraps past the memory size, input and output.
    task automatic test_load_store();
        send_word(mk(OP_LOAD, 4'd1, NO_REG, 16'h7FFF));
        send_word(mk(OP_LOAD, 4'd2, NO_REG, 16'h8000));
        send_word(mk(OP_LOAD, 4'd6, NO_REG, 16'hFFFF));
        send_word(mk(OP_LOAD, 4'd6, 4'd1, 16'h0000));
        send_word(mk(OP_LOAD, 4'd3, 4'd6, 16'h0000));
        send_word(mk(OP_IN, 4'd4, NO_REG, 16'h0000, 16'h8000));
        send_word(mk(OP_IN, 4'd15, NO_REG, 16'hFFFF, 16'h7FFF));
        send_word(mk(OP_OUT, 4'd4, NO_REG, 16'h0000));
    endtask

    // Wrapping arithmetic, zero divisor, divide overflow, logic ops and an unknown code.
    task automatic test_arith();
        send_word(mk(OP_ADD, 4'd1, NO_REG, 16'h0001));
        send_word(mk(OP_SUB, 4'd2, NO_REG, 16'h0001));
        send_word(mk(OP_MUL, 4'd15, 4'd6, 16'h0000));
        send_word(mk(OP_DIV, 4'd2, NO_REG, 16'h0000));
        send_word(mk(OP_DIV, 4'd1, NO_REG, 16'hFFFF));
        send_word(mk(OP_AND, 4'd3, NO_REG, 16'h0000));
        send_word(mk(OP_OR, 4'd3, 4'd6, 16'h0000));
        send_word(mk(OP_NOT, 4'd3, NO_REG, 16'h0000));
        send_word(mk(OP_NOT, 4'd0, 4'd6, 16'h0000));
        send_word(mk(8'hFF, 4'd1, 4'd2, 16'hFFFF));
        send_word(mk(OP_OUT, 4'd1, NO_REG, 16'h0000));
    endtask

    // Each compare outcome followed by taken and not-taken jumps, negative offsets that
    // truncate toward zero, and a jump with an undefined condition.
    task automatic test_compare_jump();
        send_word(mk(OP_CMP, 4'd1, NO_REG, 16'h8000));
        send_word(mk(OP_JMP, 4'd0, JC_EQ, 16'hFFFB));
        send_word(mk(OP_JMP, 4'd0, JC_GT, 16'h0040));
        send_word(mk(OP_CMP, 4'd2, NO_REG, 16'h8000));
        send_word(mk(OP_JMP, 4'd0, JC_GT, 16'h7FFF));
        send_word(mk(OP_CMP, 4'd4, NO_REG, 16'h0000));
        send_word(mk(OP_JMP, 4'd0, JC_LT, 16'h8000));
        send_word(mk(OP_JMP, 4'd0, JC_LT + 4'd1, 16'h0100));
        send_word(mk(OP_JMP, 4'd0, JC_ALWAYS, 16'h0004));
    endtask

    task automatic test_random(input int count);
        repeat (count)
            send_word(random_word());
    endtask

    // The sender stops and waits for the pipeline to empty halfway through.
    task automatic test_pause();
        test_random(60);
        wait_drained();
        test_random(60);
    endtask

    // A long stretch in which neither side ever idles.
    task automatic test_streaming();
        idle_on = 1'b0;
        test_random(300);
        idle_on = 1'b1;
    endtask

    // The receiver holds off for a long time while the sender keeps offering beats,
    // so the block fills up and must stall its command side.
    task automatic test_backpressure();
        hold_req = 1'b1;
        test_random(40);
        wait_drained();
    endtask

    // Halt, then a few words that must all be ignored.
    task automatic test_halt();
        send_word(mk(OP_HALT, 4'd0, NO_REG, 16'h0000));
        test_random(4);
    endtask

    // Receiver: random stalls at the falling edge, or one long hold-off on request.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else
                rsp_stall <= idle_on && ($urandom_range(99) < 14);
        end
    end

    // Every reported beat is matched against the oldest retired instruction.
    always @(posedge clk)
    begin
        out_item_t want;

        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (retire_q.size() == 0)
            begin
                $error("result beat arrived with no instruction outstanding");
                fail_count++;
            end
            else
            begin
                want = retire_q.pop_front();
                check_field("next_pc", want.next_pc, rsp.next_pc);
                check_field("out_valid", want.out_valid, rsp.out_valid);
                check_field("out_value", want.out_value, rsp.out_value);
                check_field("halted", want.halted, rsp.halted);
                check_field("div_error", want.div_error, rsp.div_error);
            end
        end
    end

    // Ends the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd          = '0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        fail_count   = 0;
        quiet_cycles = 0;
        foreach (arch_regs[k])
            arch_regs[k] = '0;
        foreach (arch_mem[k])
            arch_mem[k] = '0;
        arch_flag   = FLAG_EQ;
        arch_pc     = '0;
        arch_halted = 1'b0;

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The first beat simply waits out the memory clearing pass behind cmd_stall.
        test_load_store();
        test_arith();
        test_compare_jump();
        test_pause();
        test_random(1300);
        test_streaming();
        test_backpressure();
        test_random(150);
        test_halt();

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && retire_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/tcd_pkg.sv
sv/tcd_regfile.sv
sv/tcd_dmem.sv
sv/tcd_alu.sv
sv/toy_cpu_decode_execute.sv
sv/tcd_check.sv
dv/tb.sv
